// File: hdl/mandelbrot_escape_time_pixel_defines.svh
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

// Check cons in the same cycle as ante.
`define MBET_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define MBET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mbet_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: shared package
// Fixed-point formats, register codes, sequencer states and the color ramp.
// ----------------------------------------------------------------------------
package mbet_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 28;
    localparam int PIX_W      = 12;
    localparam int ITER_W     = 10;
    localparam int COLOR_W    = 8;
    localparam int STEP_W     = COORD_BITS - 1;

    localparam int SQ_W   = FRAC_BITS + 2;
    localparam int SQR_W  = FRAC_BITS + 4;
    localparam int MUL_W  = (COORD_BITS > SQ_W) ? COORD_BITS : SQ_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int MAP_W  = PIX_W + STEP_W;
    localparam int CW     = COORD_BITS + PIX_W + 1;
    localparam int XW     = ((CW > FRAC_BITS + 4) ? CW : FRAC_BITS + 4) + 1;

    localparam logic signed [63:0] ONE_FX = 64'sd1 <<< FRAC_BITS;

    localparam logic signed [COORD_BITS-1:0] RESET_MIN_RE =
        COORD_BITS'(-(ONE_FX <<< 1));
    localparam logic signed [COORD_BITS-1:0] RESET_MIN_IM =
        COORD_BITS'(-((ONE_FX * 3) / 2));
    localparam logic [STEP_W-1:0] RESET_STEP =
        STEP_W'((ONE_FX * 3 + 400) / 800);
    localparam logic [ITER_W-1:0] RESET_MAX_ITER = ITER_W'(200);

    localparam logic signed [XW-1:0]  LIM_POS = XW'(ONE_FX <<< 1);
    localparam logic signed [XW-1:0]  LIM_NEG = XW'(-(ONE_FX <<< 1));
    localparam logic signed [SQR_W:0] FOUR_FX = (SQR_W + 1)'(ONE_FX <<< 2);

    localparam logic [ITER_W-1:0]  BAND1_END = ITER_W'(60);
    localparam logic [ITER_W-1:0]  BAND2_END = ITER_W'(120);
    localparam logic [ITER_W-1:0]  BAND3_END = ITER_W'(180);
    localparam logic [COLOR_W-1:0] COLOR_MAX = COLOR_W'(255);

    typedef enum logic [1:0] {
        REG_MIN_RE   = 2'd0,
        REG_MIN_IM   = 2'd1,
        REG_STEP     = 2'd2,
        REG_MAX_ITER = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP_RE,
        S_MAP_IM,
        S_INIT,
        S_SQX,
        S_SQY,
        S_XY,
        S_UPD
    } state_t;

    // d * 255 / 60 = d * 17 / 4, saturated at full scale
    function automatic logic [COLOR_W-1:0] ramp(input logic [ITER_W-1:0] d);
        logic [ITER_W+4:0] t;
        t = ({5'b0, d} << 4) + {5'b0, d};
        if (|t[ITER_W+4:10])
            return COLOR_MAX;
        return t[9:2];
    endfunction

endpackage

// File: hdl/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel engine
// Maps a pixel to c = min + pixel * step, iterates z = z*z + c on one shared
// multiplier and returns the escape count with an RGB color.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_write with cfg_index and cfg_data writes one register
//   (min_re, min_im, pixel_step, max_iterations) at the clock edge; the user
//   writes only while busy is low, which the block itself does not enforce.
//   Input: a beat of pixel_x/pixel_y is taken when start is high and busy is
//   low. busy stays high until the result is out.
//   Output: red, green, blue and escape_count are valid for the one cycle in
//   which done is high; the receiver cannot stall, so the beat is taken then.
//   Loop: it stops on the limit or on |x| or |y| reaching 2.0 in S_SQX, and
//   on |z|^2 reaching 4.0 in S_XY; the iteration count then is the escape
//   count. Each iteration steps through S_SQX, S_SQY, S_XY and S_UPD: x*x,
//   y*y and x*y pass one at a time through the single registered
//   multiplier, then z updates.
//   A new beat may be taken in the same cycle in which done is high.
//   Reset: registers return to min_re = -2.0, min_im = -1.5,
//   pixel_step = 3/800, max_iterations = 200; the engine goes idle.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_defines.svh"

module mandelbrot_escape_time_pixel
    import mbet_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [PIX_W-1:0]      pixel_x,
    input  logic [PIX_W-1:0]      pixel_y,
    output logic                  done,
    output logic [COLOR_W-1:0]    red,
    output logic [COLOR_W-1:0]    green,
    output logic [COLOR_W-1:0]    blue,
    output logic [ITER_W-1:0]     escape_count
);

    logic signed [COORD_BITS-1:0] min_re_reg;
    logic signed [COORD_BITS-1:0] min_im_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [ITER_W-1:0]            max_iter_reg;

    state_t state_reg, state_next;

    logic [PIX_W-1:0]        px_reg, px_next;
    logic [PIX_W-1:0]        py_reg, py_next;
    logic signed [CW-1:0]    cre_reg, cre_next;
    logic signed [CW-1:0]    cim_reg, cim_next;
    logic signed [XW-1:0]    x_reg, x_next;
    logic signed [XW-1:0]    y_reg, y_next;
    logic signed [SQR_W-1:0] xx_reg, xx_next;
    logic signed [SQR_W-1:0] yy_reg, yy_next;
    logic [ITER_W-1:0]       n_reg, n_next;
    logic                    done_reg, done_next;
    logic [COLOR_W-1:0]      red_reg, red_next;
    logic [COLOR_W-1:0]      green_reg, green_next;
    logic [COLOR_W-1:0]      blue_reg, blue_next;
    logic [ITER_W-1:0]       count_reg, count_next;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [MAP_W-1:0]         map_prod;
    logic signed [SQR_W-1:0]  sq_res;
    logic signed [SQR_W:0]    sum_sq;
    logic signed [CW-1:0]     min_re_ext;
    logic signed [CW-1:0]     min_im_ext;
    logic signed [CW-1:0]     map_ext;
    logic                     out_of_range;
    logic [COLOR_W-1:0]       col_r;
    logic [COLOR_W-1:0]       col_g;
    logic [COLOR_W-1:0]       col_b;

    mbet_mult u_mult
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_re_reg   <= RESET_MIN_RE;
            min_im_reg   <= RESET_MIN_IM;
            step_reg     <= RESET_STEP;
            max_iter_reg <= RESET_MAX_ITER;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_MIN_RE:   min_re_reg   <= signed'(cfg_data);
                REG_MIN_IM:   min_im_reg   <= signed'(cfg_data);
                REG_STEP:     step_reg     <= cfg_data[STEP_W-1:0];
                REG_MAX_ITER: max_iter_reg <= cfg_data[ITER_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        cre_reg   <= cre_next;
        cim_reg   <= cim_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        xx_reg    <= xx_next;
        yy_reg    <= yy_next;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        count_reg <= count_next;
    end

    assign map_prod   = prod[MAP_W-1:0];
    assign sq_res     = prod[2*FRAC_BITS+3:FRAC_BITS];
    assign sum_sq     = (SQR_W + 1)'(xx_reg) + (SQR_W + 1)'(sq_res);
    assign min_re_ext = CW'(min_re_reg);
    assign min_im_ext = CW'(min_im_reg);
    assign map_ext    = signed'({{(CW - MAP_W){1'b0}}, map_prod});

    assign out_of_range = (x_reg >= LIM_POS) || (x_reg <= LIM_NEG) ||
                          (y_reg >= LIM_POS) || (y_reg <= LIM_NEG);

    always_comb
    begin
        col_r = '0;
        col_g = '0;
        col_b = '0;
        priority if (n_reg == max_iter_reg)
        begin
            col_r = '0;
        end
        else if (n_reg <= BAND1_END)
        begin
            col_r = ramp(n_reg);
            col_g = COLOR_MAX;
        end
        else if (n_reg <= BAND2_END)
        begin
            col_r = COLOR_MAX;
            col_g = COLOR_MAX - ramp(n_reg - BAND1_END);
        end
        else if (n_reg <= BAND3_END)
        begin
            col_g = COLOR_MAX - ramp(n_reg - BAND2_END);
            col_b = COLOR_MAX;
        end
        else
        begin
            col_r = COLOR_MAX;
            col_b = COLOR_MAX - ramp(n_reg - BAND3_END);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        cre_next   = cre_reg;
        cim_next   = cim_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        xx_next    = xx_reg;
        yy_next    = yy_reg;
        n_next     = n_reg;
        done_next  = 1'b0;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        count_next = count_reg;
        mul_a      = '0;
        mul_b      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    px_next    = pixel_x;
                    py_next    = pixel_y;
                    n_next     = '0;
                    state_next = S_MAP_RE;
                end
            end
            S_MAP_RE:
            begin
                mul_a      = signed'(MUL_W'(px_reg));
                mul_b      = signed'(MUL_W'(step_reg));
                state_next = S_MAP_IM;
            end
            S_MAP_IM:
            begin
                mul_a      = signed'(MUL_W'(py_reg));
                mul_b      = signed'(MUL_W'(step_reg));
                cre_next   = min_re_ext + map_ext;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cim_next   = min_im_ext + map_ext;
                x_next     = '0;
                y_next     = '0;
                state_next = S_SQX;
            end
            S_SQX:
            begin
                mul_a = MUL_W'(signed'(x_reg[SQ_W-1:0]));
                mul_b = MUL_W'(signed'(x_reg[SQ_W-1:0]));
                if ((n_reg == max_iter_reg) || out_of_range)
                begin
                    red_next   = col_r;
                    green_next = col_g;
                    blue_next  = col_b;
                    count_next = n_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                mul_a      = MUL_W'(signed'(y_reg[SQ_W-1:0]));
                mul_b      = MUL_W'(signed'(y_reg[SQ_W-1:0]));
                xx_next    = sq_res;
                state_next = S_XY;
            end
            S_XY:
            begin
                mul_a   = MUL_W'(signed'(x_reg[SQ_W-1:0]));
                mul_b   = MUL_W'(signed'(y_reg[SQ_W-1:0]));
                yy_next = sq_res;
                if (sum_sq >= FOUR_FX)
                begin
                    red_next   = col_r;
                    green_next = col_g;
                    blue_next  = col_b;
                    count_next = n_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                x_next     = XW'(xx_reg) - XW'(yy_reg) + XW'(cre_reg);
                y_next     = (XW'(sq_res) <<< 1) + XW'(cim_reg);
                n_next     = n_reg + ITER_W'(1);
                state_next = S_SQX;
            end
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign escape_count = count_reg;

    `MBET_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted beat did not raise busy")
    `MBET_ASSERT_SAME(a_count_bound, busy, n_reg <= max_iter_reg, "iteration count passed limit")
    `MBET_ASSERT_SAME(a_done_count, done, escape_count <= max_iter_reg, "escape count above limit")
    `MBET_ASSERT_SAME(a_inside_black, done && (escape_count == max_iter_reg), (red == '0) && (green == '0) && (blue == '0), "inside point not black")
    `MBET_ASSERT_SAME(a_done_idle, done, !busy, "result shown while busy")

endmodule

// File: hdl/mbet_mult.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: shared multiplier
// Signed full-width product with a registered output, one result per cycle.
// ----------------------------------------------------------------------------
module mbet_mult
    import mbet_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the Mandelbrot escape-time pixel engine
// Sends pixel beats through the start/busy handshake in random bursts and
// compares every done beat with the escape count and color that a local
// fixed-point predictor works out. The view registers are reprogrammed
// between phases, and only while the engine is idle.
// ----------------------------------------------------------------------------
module tb;
    import mbet_pkg::*;

    localparam int     MAX_GAP = 300;
    localparam int     BAND    = 60;
    localparam longint FX_TWO  = longint'(2) << FRAC_BITS;
    localparam longint FX_FOUR = longint'(4) << FRAC_BITS;

    localparam int VIEW_MIN_RE = -(9 << (FRAC_BITS - 2));
    localparam int VIEW_MIN_IM = -(3 << (FRAC_BITS - 1));
    localparam int VIEW_STEP   = 3 << (FRAC_BITS - 12);
    localparam int SEA_MIN_RE  = -(3 << (FRAC_BITS - 2)) - (1 << (FRAC_BITS - 7));
    localparam int SEA_MIN_IM  = 1 << (FRAC_BITS - 4);
    localparam int SEA_STEP    = 1 << (FRAC_BITS - 18);
    localparam int CUSP_RE     = 1 << (FRAC_BITS - 2);
    localparam int CUSP_STEP   = 1 << (FRAC_BITS - 16);

    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_CONFIG,
        OP_DRAIN
    } stim_kind_t;

    typedef struct packed {
        stim_kind_t            kind;
        logic [PIX_W-1:0]      px;
        logic [PIX_W-1:0]      py;
        cfg_index_t            idx;
        logic [COORD_BITS-1:0] data;
    } stim_op_t;

    typedef struct packed {
        logic [PIX_W-1:0]   px;
        logic [PIX_W-1:0]   py;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [ITER_W-1:0]  count;
    } pixel_color_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    cfg_index_t            cfg_index = REG_MIN_RE;
    logic [COORD_BITS-1:0] cfg_data  = '0;
    logic                  start     = 1'b0;
    logic [PIX_W-1:0]      pixel_x   = '0;
    logic [PIX_W-1:0]      pixel_y   = '0;
    logic                  busy;
    logic                  done;
    logic [COLOR_W-1:0]    red;
    logic [COLOR_W-1:0]    green;
    logic [COLOR_W-1:0]    blue;
    logic [ITER_W-1:0]     escape_count;

    stim_op_t     pending_beats[$];
    pixel_color_t expected_colors[$];

    longint      view_min_re   = -(longint'(2) << FRAC_BITS);
    longint      view_min_im   = -(longint'(3) << FRAC_BITS) / 2;
    longint      view_step     = ((longint'(3) << FRAC_BITS) + 400) / 800;
    int unsigned view_max_iter = 200;

    int unsigned plan_limit  = 200;
    longint      budget      = 0;
    longint      cycle_limit = 0;
    longint      cycle_count = 0;
    int          fail_count  = 0;
    int          burst_left  = 0;
    int          gap_left    = 0;
    logic        hold_start;
    logic        next_write;
    logic        engine_idle;
    stim_op_t    op;
    pixel_color_t want;
    logic [31:0] rnd_step;
    int unsigned cusp_cols [13] = '{0, 1, 3, 6, 10, 18, 27, 40, 80, 300, 720, 2000, 4095};

    mandelbrot_escape_time_pixel DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .done         (done),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .escape_count (escape_count)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [COLOR_W-1:0] band_level(input int unsigned d);
        int unsigned v;
        v = d * 255 / BAND;
        return (v > 255) ? 8'd255 : COLOR_W'(v);
    endfunction

    function automatic pixel_color_t escape_color(input logic [PIX_W-1:0] px,
                                                  input logic [PIX_W-1:0] py);
        longint       c_re, c_im, zr, zi, zr2, zi2, zri;
        int unsigned  n;
        logic         gone;
        pixel_color_t res;
        c_re = view_min_re + longint'(px) * view_step;
        c_im = view_min_im + longint'(py) * view_step;
        zr   = 0;
        zi   = 0;
        n    = 0;
        gone = 1'b0;
        while (n < view_max_iter && !gone)
        begin
            if (zr >= FX_TWO || zr <= -FX_TWO || zi >= FX_TWO || zi <= -FX_TWO)
                gone = 1'b1;
            else
            begin
                zr2 = (zr * zr) >>> FRAC_BITS;
                zi2 = (zi * zi) >>> FRAC_BITS;
                if (zr2 + zi2 >= FX_FOUR)
                    gone = 1'b1;
                else
                begin
                    zri = (zr * zi) >>> FRAC_BITS;
                    zr  = zr2 - zi2 + c_re;
                    zi  = 2 * zri + c_im;
                    n++;
                end
            end
        end
        res.px    = px;
        res.py    = py;
        res.count = ITER_W'(n);
        res.red   = '0;
        res.green = '0;
        res.blue  = '0;
        if (n == view_max_iter)
            res.count = ITER_W'(n);
        else if (n <= BAND)
        begin
            res.red   = band_level(n);
            res.green = 8'd255;
        end
        else if (n <= 2 * BAND)
        begin
            res.red   = 8'd255;
            res.green = 8'd255 - band_level(n - BAND);
        end
        else if (n <= 3 * BAND)
        begin
            res.green = 8'd255 - band_level(n - 2 * BAND);
            res.blue  = 8'd255;
        end
        else
        begin
            res.red  = 8'd255;
            res.blue = 8'd255 - band_level(n - 3 * BAND);
        end
        return res;
    endfunction

    task automatic queue_pixel(input int unsigned px, input int unsigned py);
        stim_op_t s;
        s      = '0;
        s.kind = OP_PIXEL;
        s.px   = PIX_W'(px);
        s.py   = PIX_W'(py);
        pending_beats.push_back(s);
        budget += 4 * plan_limit + 11 + MAX_GAP;
    endtask

    task automatic queue_config(input cfg_index_t idx, input logic [31:0] data);
        stim_op_t s;
        s      = '0;
        s.kind = OP_CONFIG;
        s.idx  = idx;
        s.data = data;
        pending_beats.push_back(s);
        if (idx == REG_MAX_ITER)
            plan_limit = data[ITER_W-1:0];
        budget += 16;
    endtask

    task automatic queue_drain();
        stim_op_t s;
        s      = '0;
        s.kind = OP_DRAIN;
        pending_beats.push_back(s);
        budget += 16;
    endtask

    task automatic queue_phase(input logic [31:0] re0, input logic [31:0] im0,
                               input logic [31:0] stride, input logic [31:0] lim,
                               input int count);
        queue_config(REG_MIN_RE, re0);
        queue_config(REG_MIN_IM, im0);
        queue_config(REG_STEP, stride);
        queue_config(REG_MAX_ITER, lim);
        repeat (count)
        begin
            if ($urandom_range(0, 39) == 0)
                queue_drain();
            queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            cfg_write <= 1'b0;
            cfg_index <= REG_MIN_RE;
            cfg_data  <= '0;
            pixel_x   <= '0;
            pixel_y   <= '0;
        end
        else
        begin
            hold_start  = start && busy;
            next_write  = 1'b0;
            engine_idle = !start && !busy && !done && !cfg_write &&
                          expected_colors.size() == 0;
            if (!hold_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_beats.size() > 0)
                begin
                    op = pending_beats[0];
                    case (op.kind)
                        OP_PIXEL:
                        begin
                            op         = pending_beats.pop_front();
                            pixel_x    <= op.px;
                            pixel_y    <= op.py;
                            hold_start = 1'b1;
                            if (burst_left > 0)
                                burst_left--;
                            else
                            begin
                                burst_left = $urandom_range(0, 15);
                                case ($urandom_range(0, 9))
                                    0, 1, 2, 3, 4: gap_left = 0;
                                    5, 6, 7:       gap_left = $urandom_range(1, 4);
                                    8:             gap_left = $urandom_range(5, 40);
                                    default:       gap_left = $urandom_range(41, MAX_GAP);
                                endcase
                            end
                        end
                        OP_CONFIG:
                            if (engine_idle)
                            begin
                                op         = pending_beats.pop_front();
                                cfg_index  <= op.idx;
                                cfg_data   <= op.data;
                                next_write = 1'b1;
                            end
                        default:
                            if (engine_idle)
                                op = pending_beats.pop_front();
                    endcase
                end
            end
            start     <= hold_start;
            cfg_write <= next_write;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_colors.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result beat with no pixel pending: rgb=%0d,%0d,%0d n=%0d",
                                 red, green, blue, escape_count);
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (want.red !== red || want.green !== green || want.blue !== blue ||
                        want.count !== escape_count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("pixel (%0d,%0d): expected rgb=%0d,%0d,%0d n=%0d, got rgb=%0d,%0d,%0d n=%0d",
                                     want.px, want.py, want.red, want.green, want.blue,
                                     want.count, red, green, blue, escape_count);
                    end
                end
            end
            if (cfg_write)
                case (cfg_index)
                    REG_MIN_RE:   view_min_re   = longint'($signed(cfg_data));
                    REG_MIN_IM:   view_min_im   = longint'($signed(cfg_data));
                    REG_STEP:     view_step     = longint'(cfg_data[STEP_W-1:0]);
                    REG_MAX_ITER: view_max_iter = cfg_data[ITER_W-1:0];
                endcase
            if (start && !busy)
                expected_colors.push_back(escape_color(pixel_x, pixel_y));
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("FAIL mandelbrot_escape_time_pixel");
            $finish;
        end
    end

    initial
    begin
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(4095, 0);
        queue_pixel(0, 4095);
        queue_pixel(533, 400);
        queue_pixel(100, 400);
        queue_drain();
        queue_config(REG_MAX_ITER, 0);
        queue_pixel(533, 400);
        queue_pixel(0, 0);
        queue_config(REG_MIN_RE, CUSP_RE);
        queue_config(REG_MIN_IM, 0);
        queue_config(REG_STEP, CUSP_STEP);
        queue_config(REG_MAX_ITER, 1023);
        foreach (cusp_cols[i])
            queue_pixel(cusp_cols[i], 0);
        queue_pixel(0, 4095);

        queue_phase(VIEW_MIN_RE, VIEW_MIN_IM, VIEW_STEP, 64, 200);
        queue_phase(VIEW_MIN_RE, VIEW_MIN_IM, VIEW_STEP, $urandom_range(1, 40), 120);
        queue_phase(SEA_MIN_RE, SEA_MIN_IM, SEA_STEP, 200, 80);
        queue_phase(CUSP_RE, -(1 << (FRAC_BITS - 5)), CUSP_STEP, 1023, 30);
        queue_phase(VIEW_MIN_RE, VIEW_MIN_IM, VIEW_STEP, 1, 80);
        queue_phase(32'h8000_0000, 32'h7fff_ffff, 0, $urandom_range(1, 1023), 40);
        queue_phase(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1023, 40);
        repeat (5)
        begin
            rnd_step = $urandom_range(0, 1) ? $urandom_range(0, 1 << 20) : $urandom;
            queue_phase($urandom, $urandom, rnd_step,
                        {22'($urandom), 10'($urandom_range(1, 255))}, 80);
        end
        cycle_limit = 4 * budget + 20000;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_beats.size() != 0 || start || busy || done ||
               expected_colors.size() != 0)
            @(negedge clk);
        repeat (64) @(negedge clk);
        if (fail_count == 0 && expected_colors.size() == 0)
            $display("PASS mandelbrot_escape_time_pixel");
        else
            $display("FAIL mandelbrot_escape_time_pixel");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/mbet_pkg.sv
hdl/mbet_mult.sv
hdl/mandelbrot_escape_time_pixel.sv
test/tb.sv
